FILE: rtl/kbt_pkg.sv
// Shared constants, types and register codes for the keyed block transposition block.
package kbt_pkg;

    // Largest key the block is built for, and the block store depth
    localparam int MAX_KEY     = 8;
    localparam int STORE_DEPTH = 8;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int FILL_W      = IDX_W + 1;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int KEY_W  = 64;
    localparam int LEN_W  = 4;

    // Longest usable block
    localparam int LEN_MAX = (MAX_KEY < STORE_DEPTH) ? MAX_KEY : STORE_DEPTH;
    localparam logic [LEN_W-1:0] LEN_MAX_V = LEN_W'(LEN_MAX);
    localparam logic [LEN_W-1:0] LEN_MIN_V = LEN_W'(2);

    // Pad byte, ASCII zero
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h30;

    // Reset values of the configuration registers (key "ceayf")
    localparam logic [KEY_W-1:0] KEY_RESET = 64'h0000_0066_7961_6563;
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    // Block queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One closed, padded block
    typedef struct packed {
        logic [STORE_DEPTH-1:0][BYTE_W-1:0] data;
        logic                               last;
    } kbt_block_t;

    // Queue status seen by the front and by the checks
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } kbt_q_status_t;

endpackage

FILE: rtl/kbt_front.sv
// Front end: collects message bytes into a block and closes it with padding.
module kbt_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kbt_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    input  logic [kbt_pkg::LEN_W-1:0]           eff_len,
    input  kbt_pkg::kbt_q_status_t              q_stat,
    output logic                                q_push,
    output kbt_pkg::kbt_block_t                 q_entry
);

    logic [kbt_pkg::FILL_W-1:0]                             fill_reg, fill_next;
    logic [kbt_pkg::STORE_DEPTH-1:0][kbt_pkg::BYTE_W-1:0]   blk_reg;
    logic [kbt_pkg::FILL_W-1:0]                             fill_inc;
    logic [kbt_pkg::IDX_W-1:0]                              wr_idx;
    logic                                                   accept;
    logic                                                   close_blk;

    // Take a request whenever the queue has room
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign wr_idx    = fill_reg[kbt_pkg::IDX_W-1:0];
    assign fill_inc  = fill_reg + kbt_pkg::FILL_W'(1);
    assign close_blk = (fill_inc >= kbt_pkg::FILL_W'(eff_len)) || s_tlast;
    assign q_push    = accept && close_blk;

    // Build the padded block with the new byte in place
    always_comb begin
        for (int k = 0; k < kbt_pkg::STORE_DEPTH; k++) begin
            if (kbt_pkg::FILL_W'(k) < fill_inc) begin
                q_entry.data[k] = (kbt_pkg::IDX_W'(k) == wr_idx) ? s_tdata : blk_reg[k];
            end else begin
                q_entry.data[k] = kbt_pkg::PAD_BYTE;
            end
        end
        q_entry.last = s_tlast;
    end

    // Advance the fill count, restart after a closed block
    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            fill_next = close_blk ? '0 : fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Hold the bytes of the open block
    always_ff @(posedge aclk) begin
        if (accept && !close_blk) begin
            blk_reg[wr_idx] <= s_tdata;
        end
    end

endmodule

FILE: rtl/kbt_queue.sv
// Two-entry block queue that decouples the front end from the back end.
module kbt_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  kbt_pkg::kbt_block_t     push_entry,
    input  logic                    pop,
    output kbt_pkg::kbt_block_t     head,
    output kbt_pkg::kbt_q_status_t  stat
);

    kbt_pkg::kbt_block_t        ent_reg [kbt_pkg::QUEUE_DEPTH];
    logic [kbt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kbt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kbt_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign head       = ent_reg[rd_ptr_reg];
    assign stat.count = cnt_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == kbt_pkg::QCNT_W'(kbt_pkg::QUEUE_DEPTH));

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == kbt_pkg::QPTR_W'(kbt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + kbt_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == kbt_pkg::QPTR_W'(kbt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + kbt_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + kbt_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - kbt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write the new block
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/kbt_back.sv
// Back end: ranks the key, drains a permuted byte per cycle unless stalled.
module kbt_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kbt_pkg::KEY_W-1:0]           key_bytes,
    input  logic [kbt_pkg::LEN_W-1:0]           eff_len,
    input  logic                                decrypt_mode,
    input  logic                                q_valid,
    input  kbt_pkg::kbt_block_t                 q_head,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kbt_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast    // out_last
);

    logic [kbt_pkg::IDX_W-1:0]  rank_c   [kbt_pkg::STORE_DEPTH];
    logic [kbt_pkg::IDX_W-1:0]  inv_c    [kbt_pkg::STORE_DEPTH];
    logic [kbt_pkg::IDX_W-1:0]  src_reg  [kbt_pkg::STORE_DEPTH];
    logic [kbt_pkg::FILL_W-1:0] cnt_c;
    logic [kbt_pkg::BYTE_W-1:0] cj, ck;

    kbt_pkg::kbt_block_t        work_reg;
    logic                       work_vld_reg, work_vld_next;
    logic [kbt_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       out_vld_reg, out_vld_next;
    logic [kbt_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       out_last_reg;
    logic                       adv;
    logic                       final_byte;
    logic                       load;

    // Rank each key position: smaller bytes, ties broken by position
    always_comb begin
        for (int j = 0; j < kbt_pkg::STORE_DEPTH; j++) begin
            cnt_c = '0;
            cj    = key_bytes[j*kbt_pkg::BYTE_W +: kbt_pkg::BYTE_W];
            for (int k = 0; k < kbt_pkg::STORE_DEPTH; k++) begin
                ck = key_bytes[k*kbt_pkg::BYTE_W +: kbt_pkg::BYTE_W];
                if ((kbt_pkg::LEN_W'(k) < eff_len) && ((ck < cj) || ((ck == cj) && (k < j)))) begin
                    cnt_c = cnt_c + kbt_pkg::FILL_W'(1);
                end
            end
            rank_c[j] = cnt_c[kbt_pkg::IDX_W-1:0];
        end
    end

    // Invert the ranking for the scatter direction
    always_comb begin
        for (int i = 0; i < kbt_pkg::STORE_DEPTH; i++) begin
            inv_c[i] = '0;
            for (int p = 0; p < kbt_pkg::STORE_DEPTH; p++) begin
                if ((kbt_pkg::LEN_W'(p) < eff_len) && (rank_c[p] == kbt_pkg::IDX_W'(i))) begin
                    inv_c[i] = kbt_pkg::IDX_W'(p);
                end
            end
        end
    end

    // Register the source index of each output position
    always_ff @(posedge aclk) begin
        for (int i = 0; i < kbt_pkg::STORE_DEPTH; i++) begin
            src_reg[i] <= decrypt_mode ? inv_c[i] : rank_c[i];
        end
    end

    // Drain control
    assign adv        = work_vld_reg && (!out_vld_reg || m_tready);
    assign final_byte = ((kbt_pkg::LEN_W'(idx_reg) + kbt_pkg::LEN_W'(1)) == eff_len);
    assign load       = q_valid && (!work_vld_reg || (adv && final_byte));
    assign q_pop      = load;

    always_comb begin
        work_vld_next = work_vld_reg;
        idx_next      = idx_reg;
        if (load) begin
            work_vld_next = 1'b1;
            idx_next      = '0;
        end else if (adv) begin
            if (final_byte) begin
                work_vld_next = 1'b0;
                idx_next      = '0;
            end else begin
                idx_next = idx_reg + kbt_pkg::IDX_W'(1);
            end
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (adv) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_vld_reg <= 1'b0;
            idx_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            work_vld_reg <= work_vld_next;
            idx_reg      <= idx_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Hold the block being drained
    always_ff @(posedge aclk) begin
        if (load) begin
            work_reg <= q_head;
        end
    end

    // Output register: gather the byte at the source index
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_byte_reg <= work_reg.data[src_reg[idx_reg]];
            out_last_reg <= work_reg.last && final_byte;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/keyed_block_transposition.sv
// Top level of the keyed block transposition block: config registers and wiring.
//
//  Port group  Dir  Carries
//  s_*         in   message bytes: tdata[7:0] data_byte, tlast last_byte
//  m_*         out  permuted bytes: tdata[7:0] out_byte, tlast out_last
//  cfg_*       in   register writes: cfg_index, cfg_data (always ready)
//
// One byte is accepted per cycle while the queue has room; a closed block waits
// in a two-entry queue and drains one byte per cycle while the output is not
// stalled, through the output register, once the back end picks it up.
// Reset (aresetn low, synchronous) empties the block, the queue and the output.
// Input stalls only when the queue is full; output stalls hold the output register.
module keyed_block_transposition (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kbt_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kbt_pkg::BYTE_W-1:0]          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,   // out_last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kbt_pkg::KEY_W-1:0]           cfg_data
);

    logic [kbt_pkg::KEY_W-1:0]  key_reg;
    logic [kbt_pkg::LEN_W-1:0]  len_reg;
    logic                       dec_reg;
    logic [kbt_pkg::LEN_W-1:0]  eff_len;

    kbt_pkg::kbt_block_t        q_entry;
    kbt_pkg::kbt_block_t        q_head;
    kbt_pkg::kbt_q_status_t     q_stat;
    logic                       q_push;
    logic                       q_pop;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= kbt_pkg::KEY_RESET;
            len_reg <= kbt_pkg::LEN_RESET;
            dec_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kbt_pkg::CFG_KEY_BYTES:    key_reg <= cfg_data;
                kbt_pkg::CFG_KEY_LENGTH:   len_reg <= cfg_data[kbt_pkg::LEN_W-1:0];
                kbt_pkg::CFG_DECRYPT_MODE: dec_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturate the block length to the usable range
    always_comb begin
        if (len_reg < kbt_pkg::LEN_MIN_V) begin
            eff_len = kbt_pkg::LEN_MIN_V;
        end else if (len_reg > kbt_pkg::LEN_MAX_V) begin
            eff_len = kbt_pkg::LEN_MAX_V;
        end else begin
            eff_len = len_reg;
        end
    end

    kbt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .eff_len  (eff_len),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    kbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    kbt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_bytes    (key_reg),
        .eff_len      (eff_len),
        .decrypt_mode (dec_reg),
        .q_valid      (!q_stat.empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // Never close a block into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("block pushed into full queue");

    // Never pick up a block from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("block popped from empty queue");

    // Queue count stays within its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= kbt_pkg::QCNT_W'(kbt_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    // Input is open right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule
